@@ hdl/lmt_pkg.sv @@
`timescale 1ns / 1ps

package lmt_pkg;

   // Field widths fixed by the request and response formats
   localparam int MODE_W   = 2;
   localparam int TID_W    = 6;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_LOCK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRY    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNLOCK = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BUSY    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

   localparam int RSP_FIELD_W = STATUS_W + 1 + TID_W;
   localparam int RSP_W       = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef struct packed {
      logic load_req;
      logic search;
      logic exec;
      logic link;
      logic emit;
   } lmt_cmd_type;

   typedef struct packed {
      logic mode_ok;
      logic full;
      logic need_link;
      logic out_free;
   } lmt_stat_type;

endpackage

@@ hdl/lmt_ctrl.sv @@
`timescale 1ns / 1ps

module lmt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lmt_pkg::lmt_stat_type stat,
   output lmt_pkg::lmt_cmd_type  cmd
);
   import lmt_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_READ   = 6'b000100,
      ST_EXEC   = 6'b001000,
      ST_LINK   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            // skip the entry access for an unknown mode or a full table
            state_in = (stat.mode_ok && !stat.full) ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_link ? ST_LINK : ST_DONE;
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/lmt_dpath.sv @@
`timescale 1ns / 1ps

module lmt_dpath #(
   parameter int LOCK_ENTRIES = 16,
   parameter int THREADS      = 64,
   parameter int KEY_BITS     = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lmt_pkg::lmt_cmd_type          cmd,
   output lmt_pkg::lmt_stat_type         stat,
   input  logic [lmt_pkg::MODE_W-1:0]    mode,
   input  logic [KEY_BITS-1:0]           lock_key,
   input  logic [lmt_pkg::TID_W-1:0]     thread_id,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lmt_pkg::STATUS_W-1:0]  rsp_status_code,
   output logic                          rsp_woke_valid,
   output logic [lmt_pkg::TID_W-1:0]     rsp_woke_thread
);
   import lmt_pkg::*;

   localparam int SLOT_W = $clog2(LOCK_ENTRIES);
   localparam int TIX_W  = $clog2(THREADS);
   localparam int ENT_W  = 2 + 2 * TIX_W;
   localparam int TID_N  = 2 ** TID_W;

   // Entry word: locked, queue nonempty, queue head, queue tail
   localparam int LOCKED_BIT   = ENT_W - 1;
   localparam int NONEMPTY_BIT = ENT_W - 2;

   // Request latch
   logic [MODE_W-1:0]   mode_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [TIX_W-1:0]    tix_ff;
   logic [TIX_W-1:0]    tid_mod_tbl [TID_N];

   genvar g;
   generate
      for (g = 0; g < TID_N; g++) begin : g_tid_mod
         assign tid_mod_tbl[g] = TIX_W'(g % THREADS);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= mode;
         key_ff  <= lock_key;
         tix_ff  <= tid_mod_tbl[thread_id];
      end
   end

   // Key table: one comparator per slot
   logic [LOCK_ENTRIES-1:0] valid_ff;
   logic [KEY_BITS-1:0]     key_tbl_ff [LOCK_ENTRIES];
   logic                    hit, free;
   logic [SLOT_W-1:0]       hit_slot, free_slot;
   logic                    mode_ok, full;
   logic [SLOT_W-1:0]       slot_ff;
   logic                    hit_ff;

   always_comb begin
      hit       = 1'b0;
      free      = 1'b0;
      hit_slot  = '0;
      free_slot = '0;
      for (int i = 0; i < LOCK_ENTRIES; i++) begin
         if (valid_ff[i]) begin
            if (!hit && key_tbl_ff[i] == key_ff) begin
               hit      = 1'b1;
               hit_slot = SLOT_W'(i);
            end
         end else if (!free) begin
            free      = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign mode_ok = (mode_ff == MODE_LOCK) || (mode_ff == MODE_TRY) ||
                    (mode_ff == MODE_UNLOCK);
   assign full    = !hit && !free;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.search && mode_ok && !hit && free) begin
         valid_ff[free_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         slot_ff <= hit ? hit_slot : free_slot;
         hit_ff  <= hit;
         if (mode_ok && !hit && free) begin
            key_tbl_ff[free_slot] <= key_ff;
         end
      end
   end

   // Entry memory
   logic [ENT_W-1:0] ent_mem [LOCK_ENTRIES];
   logic [ENT_W-1:0] ent_rd_ff;
   logic [ENT_W-1:0] ent_wr;
   logic             cur_locked, cur_nonempty;
   logic [TIX_W-1:0] cur_head, cur_tail;

   // Waiter links
   logic [TIX_W-1:0] wait_mem [THREADS];
   logic [TIX_W-1:0] wait_rd_ff;
   logic             wait_we;

   // A freshly created entry starts unlocked with an empty queue
   assign cur_locked   = hit_ff && ent_rd_ff[LOCKED_BIT];
   assign cur_nonempty = hit_ff && ent_rd_ff[NONEMPTY_BIT];
   assign cur_head     = ent_rd_ff[TIX_W +: TIX_W];
   assign cur_tail     = ent_rd_ff[TIX_W-1:0];

   logic                new_locked, new_nonempty, need_link, woke_v;
   logic [TIX_W-1:0]    new_head, new_tail;
   logic [STATUS_W-1:0] exec_status;

   always_comb begin
      new_locked   = cur_locked;
      new_nonempty = cur_nonempty;
      new_head     = cur_head;
      new_tail     = cur_tail;
      wait_we      = 1'b0;
      need_link    = 1'b0;
      woke_v       = 1'b0;
      exec_status  = STAT_DONE;
      unique case (mode_ff)
         MODE_LOCK: begin
            if (!cur_locked) begin
               new_locked = 1'b1;
            end else begin
               exec_status = STAT_BLOCKED;
               new_tail    = tix_ff;
               if (!cur_nonempty) begin
                  new_head     = tix_ff;
                  new_nonempty = 1'b1;
               end else begin
                  wait_we = 1'b1;
               end
            end
         end
         MODE_TRY: begin
            if (!cur_locked) begin
               new_locked = 1'b1;
            end else begin
               exec_status = STAT_BUSY;
            end
         end
         MODE_UNLOCK: begin
            if (cur_nonempty) begin
               // hand off to the head waiter, entry stays locked
               new_locked = 1'b1;
               woke_v     = 1'b1;
               if (cur_head == cur_tail) begin
                  new_nonempty = 1'b0;
               end else begin
                  need_link = 1'b1;
               end
            end else begin
               new_locked = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign ent_wr = cmd.link ? {1'b1, 1'b1, wait_rd_ff, cur_tail}
                            : {new_locked, new_nonempty, new_head, new_tail};

   always_ff @(posedge clock) begin
      ent_rd_ff <= ent_mem[slot_ff];
      if (cmd.exec || cmd.link) begin
         ent_mem[slot_ff] <= ent_wr;
      end
   end

   always_ff @(posedge clock) begin
      wait_rd_ff <= wait_mem[cur_head];
      if (cmd.exec && wait_we) begin
         wait_mem[cur_tail] <= tix_ff;
      end
   end

   // Result being built
   logic [STATUS_W-1:0] res_status_ff;
   logic                res_woke_v_ff;
   logic [TIX_W-1:0]    res_woke_t_ff;

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         res_status_ff <= (mode_ok && full) ? STAT_FULL : STAT_DONE;
         res_woke_v_ff <= 1'b0;
         res_woke_t_ff <= '0;
      end else if (cmd.exec) begin
         res_status_ff <= exec_status;
         res_woke_v_ff <= woke_v;
         res_woke_t_ff <= woke_v ? cur_head : '0;
      end
   end

   // Output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_code <= res_status_ff;
         rsp_woke_valid  <= res_woke_v_ff;
         rsp_woke_thread <= TID_W'(res_woke_t_ff);
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign stat.mode_ok   = mode_ok;
   assign stat.full      = full;
   assign stat.need_link = need_link;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

@@ hdl/queued_mutex_lock_table.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    mode, lock_key, thread_id
// rsp       out  rsp_tvalid/tready    status_code, woke_valid, woke_thread
//
// A request runs search, read, exec (plus link when an unlock must follow the
// wait-queue link) and done; unknown mode or full table skips read and exec.
// The entry-memory read and the waiter-link read are each registered.
// Reset clears the slot valid bits and control at once; no clearing pass.
// A finished result waits in the output register while the next request runs.
module queued_mutex_lock_table #(
   parameter int LOCK_ENTRIES = 16,
   parameter int THREADS      = 64,
   parameter int KEY_BITS     = 48,
   localparam int REQ_W = ((lmt_pkg::MODE_W + KEY_BITS + lmt_pkg::TID_W + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_W-1:0]           req_tdata,  // mode, lock_key, thread_id
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lmt_pkg::RSP_W-1:0]  rsp_tdata   // status_code, woke_valid, woke_thread
);
   import lmt_pkg::*;

   lmt_cmd_type         cmd;
   lmt_stat_type        stat;
   logic [STATUS_W-1:0] status_code;
   logic                woke_valid;
   logic [TID_W-1:0]    woke_thread;

   lmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lmt_dpath #(
      .LOCK_ENTRIES (LOCK_ENTRIES),
      .THREADS      (THREADS),
      .KEY_BITS     (KEY_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .mode            (req_tdata[MODE_W-1:0]),
      .lock_key        (req_tdata[MODE_W +: KEY_BITS]),
      .thread_id       (req_tdata[MODE_W + KEY_BITS +: TID_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status_code (status_code),
      .rsp_woke_valid  (woke_valid),
      .rsp_woke_thread (woke_thread)
   );

   assign rsp_tdata = {{(RSP_W - RSP_FIELD_W){1'b0}}, woke_thread, woke_valid, status_code};

endmodule

@@ hdl/lmt_checker.sv @@
`timescale 1ns / 1ps

module lmt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [lmt_pkg::RSP_W-1:0] rsp_tdata
);
   import lmt_pkg::*;

   logic [STATUS_W-1:0] status_code;
   logic                woke_valid;
   logic [TID_W-1:0]    woke_thread;

   assign status_code = rsp_tdata[STATUS_W-1:0];
   assign woke_valid  = rsp_tdata[STATUS_W];
   assign woke_thread = rsp_tdata[STATUS_W + 1 +: TID_W];

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response beat changed");

   a_woke_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && woke_valid) |-> (status_code == STAT_DONE))
      else $error("woken thread reported with a non-done status");

   a_woke_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !woke_valid) |-> (woke_thread == '0))
      else $error("woke_thread nonzero without a wake");

endmodule

bind queued_mutex_lock_table lmt_checker u_lmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
